>>> sv/rht_pkg.sv
// ----------------------------------------------------------------------------
// Reference counted handle table package
// Shared widths, operation and status codes, payload types and helpers.
// ----------------------------------------------------------------------------
package rht_pkg;

    localparam int RHT_ENTRIES = 16;
    localparam int OP_W        = 3;
    localparam int HANDLE_W    = 8;
    localparam int MASK_W      = 64;
    localparam int COUNT_W     = 32;
    localparam int STATUS_W    = 2;

    localparam logic [OP_W-1:0] OP_CREATE  = 3'd0;
    localparam logic [OP_W-1:0] OP_RETAIN  = 3'd1;
    localparam logic [OP_W-1:0] OP_RELEASE = 3'd2;
    localparam logic [OP_W-1:0] OP_UPDATE  = 3'd3;
    localparam logic [OP_W-1:0] OP_QUERY   = 3'd4;

    localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
    localparam logic [STATUS_W-1:0] ST_BAD      = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL     = 2'd2;
    localparam logic [STATUS_W-1:0] ST_OVERFLOW = 2'd3;

    // Signals 9 and 19 cannot be caught.
    localparam logic [MASK_W-1:0] CLEAR_BITS = (64'd1 << 8) | (64'd1 << 18);

    typedef struct packed {
        logic [OP_W-1:0]     operation;
        logic [HANDLE_W-1:0] handle;
        logic [MASK_W-1:0]   new_mask;
    } req_t;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [HANDLE_W-1:0] allocated_handle;
        logic [MASK_W-1:0]   mask_out;
        logic [COUNT_W-1:0]  references_out;
    } rsp_t;

    typedef struct packed {
        logic                cnt_we;
        logic                mask_we;
        logic [HANDLE_W-1:0] addr;
        logic [COUNT_W-1:0]  cnt;
        logic [MASK_W-1:0]   mask;
    } store_wr_t;

    typedef struct packed {
        logic                set;
        logic                clr;
        logic [HANDLE_W-1:0] index;
    } valid_upd_t;

    function automatic logic [MASK_W-1:0] clean_mask(input logic [MASK_W-1:0] m);
        return m & ~CLEAR_BITS;
    endfunction

endpackage

>>> sv/rht_chan_if.sv
// ----------------------------------------------------------------------------
// Reference counted handle table channel
// Valid/ready channel carrying one payload per transaction.
// ----------------------------------------------------------------------------
interface rht_chan_if #(
    parameter type data_t = logic
);
    logic  valid;
    logic  ready;
    data_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

>>> sv/refcounted_handle_table.sv
// ----------------------------------------------------------------------------
// Reference counted handle table
// Allocates entries, keeps reference counts and signal masks per entry.
//
//   Channel  Direction  Payload
//   req      in         operation, handle, new_mask
//   rsp      out        status, allocated_handle, mask_out, references_out
//
// A request reads its entry from the store in the cycle it is accepted and
// is resolved and written back once the output register is free; the
// single read-modify-write slot takes no new request until its own is done.
// The result waits in an output register, and rsp stalls hold the slot.
// Reset clears the valid bits at once; no clearing pass is needed.
// ----------------------------------------------------------------------------
module refcounted_handle_table #(
    parameter int ENTRIES = rht_pkg::RHT_ENTRIES
) (
    input logic      clk,
    input logic      rst_n,
    rht_chan_if.sink   req,
    rht_chan_if.source rsp
);
    import rht_pkg::*;

    logic                req_accept;
    logic                slot_done;
    logic                slot_valid_reg;
    logic                slot_valid_next;
    req_t                slot_reg;
    logic                rsp_valid_reg;
    logic                rsp_valid_next;
    rsp_t                rsp_reg;
    rsp_t                rsp_next;
    store_wr_t           wr;
    valid_upd_t          upd;
    logic [COUNT_W-1:0]  rd_cnt;
    logic [MASK_W-1:0]   rd_mask;
    logic                lookup_ok;
    logic                free_found;
    logic [HANDLE_W-1:0] free_index;

    assign req.ready  = !slot_valid_reg;
    assign req_accept = req.valid && req.ready;
    assign slot_done  = slot_valid_reg && (!rsp_valid_reg || rsp.ready);

    rht_store #(
        .ENTRIES (ENTRIES)
    ) u_store (
        .clk     (clk),
        .rd_en   (req_accept),
        .rd_addr (req.data.handle),
        .wr      (wr),
        .rd_cnt  (rd_cnt),
        .rd_mask (rd_mask)
    );

    rht_valid #(
        .ENTRIES (ENTRIES)
    ) u_valid (
        .clk        (clk),
        .rst_n      (rst_n),
        .upd        (upd),
        .lookup     (slot_reg.handle),
        .lookup_ok  (lookup_ok),
        .free_found (free_found),
        .free_index (free_index)
    );

    always_comb
    begin
        wr       = '0;
        upd      = '0;
        rsp_next = '0;
        wr.addr  = slot_reg.handle;
        wr.cnt   = rd_cnt;
        wr.mask  = clean_mask(slot_reg.new_mask);
        upd.index = slot_reg.handle;
        case (slot_reg.operation)
            OP_CREATE:
            begin
                if (free_found)
                begin
                    wr.addr    = free_index;
                    wr.cnt     = COUNT_W'(1);
                    wr.cnt_we  = slot_done;
                    wr.mask_we = slot_done;
                    upd.index  = free_index;
                    upd.set    = slot_done;
                    rsp_next.allocated_handle = free_index;
                end
                else
                begin
                    rsp_next.status = ST_FULL;
                end
            end
            OP_RETAIN:
            begin
                if (!lookup_ok)
                begin
                    rsp_next.status = ST_BAD;
                end
                else if (rd_cnt == '1)
                begin
                    rsp_next.status = ST_OVERFLOW;
                end
                else
                begin
                    wr.cnt    = rd_cnt + COUNT_W'(1);
                    wr.cnt_we = slot_done;
                end
            end
            OP_RELEASE:
            begin
                if (lookup_ok && (rd_cnt != '0))
                begin
                    wr.cnt    = rd_cnt - COUNT_W'(1);
                    wr.cnt_we = slot_done;
                    upd.clr   = slot_done && (rd_cnt == COUNT_W'(1));
                end
            end
            OP_UPDATE:
            begin
                if (!lookup_ok)
                begin
                    rsp_next.status = ST_BAD;
                end
                else
                begin
                    wr.mask_we = slot_done;
                end
            end
            OP_QUERY:
            begin
                if (!lookup_ok)
                begin
                    rsp_next.status = ST_BAD;
                end
                else
                begin
                    rsp_next.mask_out       = rd_mask;
                    rsp_next.references_out = rd_cnt;
                end
            end
            default:
            begin
                rsp_next = '0;
            end
        endcase
    end

    always_comb
    begin
        slot_valid_next = slot_valid_reg;
        if (slot_done)
        begin
            slot_valid_next = 1'b0;
        end
        if (req_accept)
        begin
            slot_valid_next = 1'b1;
        end
        rsp_valid_next = rsp_valid_reg;
        if (rsp_valid_reg && rsp.ready)
        begin
            rsp_valid_next = 1'b0;
        end
        if (slot_done)
        begin
            rsp_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slot_valid_reg <= 1'b0;
            rsp_valid_reg  <= 1'b0;
        end
        else
        begin
            slot_valid_reg <= slot_valid_next;
            rsp_valid_reg  <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req_accept)
        begin
            slot_reg <= req.data;
        end
        if (slot_done)
        begin
            rsp_reg <= rsp_next;
        end
    end

    assign rsp.valid = rsp_valid_reg;
    assign rsp.data  = rsp_reg;

endmodule

>>> sv/rht_store.sv
// ----------------------------------------------------------------------------
// Reference counted handle table entry store
// Count and mask memories with one write port and a registered read port.
// ----------------------------------------------------------------------------
module rht_store #(
    parameter int ENTRIES = rht_pkg::RHT_ENTRIES
) (
    input  logic                         clk,
    input  logic                         rd_en,
    input  logic [rht_pkg::HANDLE_W-1:0] rd_addr,
    input  rht_pkg::store_wr_t           wr,
    output logic [rht_pkg::COUNT_W-1:0]  rd_cnt,
    output logic [rht_pkg::MASK_W-1:0]   rd_mask
);
    import rht_pkg::*;

    localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

    logic [COUNT_W-1:0] cnt_mem  [ENTRIES];
    logic [MASK_W-1:0]  mask_mem [ENTRIES];

    always_ff @(posedge clk)
    begin
        if (wr.cnt_we)
        begin
            cnt_mem[wr.addr[IDX_W-1:0]] <= wr.cnt;
        end
        if (wr.mask_we)
        begin
            mask_mem[wr.addr[IDX_W-1:0]] <= wr.mask;
        end
        if (rd_en)
        begin
            rd_cnt  <= cnt_mem[rd_addr[IDX_W-1:0]];
            rd_mask <= mask_mem[rd_addr[IDX_W-1:0]];
        end
    end

endmodule

>>> sv/rht_valid.sv
// ----------------------------------------------------------------------------
// Reference counted handle table valid bits
// Per-entry valid flags, handle lookup and lowest free entry search.
// ----------------------------------------------------------------------------
module rht_valid #(
    parameter int ENTRIES = rht_pkg::RHT_ENTRIES
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  rht_pkg::valid_upd_t          upd,
    input  logic [rht_pkg::HANDLE_W-1:0] lookup,
    output logic                         lookup_ok,
    output logic                         free_found,
    output logic [rht_pkg::HANDLE_W-1:0] free_index
);
    import rht_pkg::*;

    localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam logic [HANDLE_W:0] ENTRIES_EXT = (HANDLE_W + 1)'(ENTRIES);

    logic [ENTRIES-1:0] valid_reg;
    logic [ENTRIES-1:0] valid_next;

    always_comb
    begin
        valid_next = valid_reg;
        if (upd.set)
        begin
            valid_next[upd.index[IDX_W-1:0]] = 1'b1;
        end
        if (upd.clr)
        begin
            valid_next[upd.index[IDX_W-1:0]] = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    assign lookup_ok = ({1'b0, lookup} < ENTRIES_EXT) && valid_reg[lookup[IDX_W-1:0]];

    // The lowest free entry wins, so the scan runs from the top down.
    always_comb
    begin
        free_found = 1'b0;
        free_index = '0;
        for (int i = ENTRIES - 1; i >= 0; i--)
        begin
            if (!valid_reg[i])
            begin
                free_found = 1'b1;
                free_index = HANDLE_W'(i);
            end
        end
    end

endmodule

>>> bench/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Reference counted handle table testbench
// Drives create, retain, release, update and query requests through the
// request channel with random gaps, stalls the response channel at random,
// and compares every response field by field against an in-order queue of
// outcomes, set per step or by a behavioral model of the handle table. A short
// directed sequence covers empty, full and freed tables, handles out of
// range and unused operation codes; random fill and drain phases follow.
// ----------------------------------------------------------------------------
module testbench;
    import rht_pkg::*;

    localparam int ENTRIES      = RHT_ENTRIES;
    localparam int RANDOM_ITEMS = 750;
    localparam int PHASE_LEN    = 64;
    localparam int SETTLE       = 8;

    localparam logic [OP_W-1:0] OP_SPARE5 = 3'd5;
    localparam logic [OP_W-1:0] OP_SPARE6 = 3'd6;
    localparam logic [OP_W-1:0] OP_SPARE7 = 3'd7;

    localparam logic [MASK_W-1:0] MASK_ONES = '1;
    localparam logic [MASK_W-1:0] MASK_ZERO = '0;
    localparam logic [MASK_W-1:0] MASK_ALT  = 64'hAAAA_AAAA_AAAA_AAAA;

    typedef struct packed {
        logic [OP_W-1:0]     operation;
        logic [HANDLE_W-1:0] handle;
        logic [MASK_W-1:0]   new_mask;
        logic [7:0]          reps;
        logic                typed;
        rsp_t                want;
    } step_t;

    logic clk;
    logic rst_n;

    rht_chan_if #(.data_t(req_t)) req_if ();
    rht_chan_if #(.data_t(rsp_t)) rsp_if ();

    refcounted_handle_table u_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_if),
        .rsp   (rsp_if)
    );

    logic               slot_live [ENTRIES];
    logic [COUNT_W-1:0] slot_refs [ENTRIES];
    logic [MASK_W-1:0]  slot_mask [ENTRIES];

    rsp_t  pending_rsp[$];
    step_t directed_steps[$];

    int  error_count;
    int  checked_count;
    int  ok_count;
    int  bad_count;
    int  full_count;
    int  peak_live;
    int  stall_left;
    bit  calm_phase;

    always
    begin
        clk = 1'b0;
        #10;
        clk = 1'b1;
        #10;
    end

    function automatic rsp_t apply_handle_op(input req_t r);
        rsp_t o;
        bit   found;
        bit   handle_live;
        int   h;
        int   live_n;
        o = '0;
        found = 1'b0;
        h = int'(r.handle);
        handle_live = (h < ENTRIES) ? slot_live[h] : 1'b0;
        case (r.operation)
            OP_CREATE:
            begin
                o.status = ST_FULL;
                for (int i = 0; i < ENTRIES; i++)
                begin
                    if (!found && !slot_live[i])
                    begin
                        found = 1'b1;
                        slot_live[i] = 1'b1;
                        slot_refs[i] = COUNT_W'(1);
                        slot_mask[i] = r.new_mask & ~CLEAR_BITS;
                        o.status = ST_OK;
                        o.allocated_handle = HANDLE_W'(i);
                    end
                end
            end
            OP_RETAIN:
            begin
                if (!handle_live)
                    o.status = ST_BAD;
                else if (slot_refs[h] == '1)
                    o.status = ST_OVERFLOW;
                else
                    slot_refs[h] = slot_refs[h] + COUNT_W'(1);
            end
            OP_RELEASE:
            begin
                if (handle_live && slot_refs[h] != '0)
                begin
                    slot_refs[h] = slot_refs[h] - COUNT_W'(1);
                    if (slot_refs[h] == '0)
                    begin
                        slot_live[h] = 1'b0;
                        slot_mask[h] = '0;
                    end
                end
            end
            OP_UPDATE:
            begin
                if (!handle_live)
                    o.status = ST_BAD;
                else
                    slot_mask[h] = r.new_mask & ~CLEAR_BITS;
            end
            OP_QUERY:
            begin
                if (!handle_live)
                    o.status = ST_BAD;
                else
                begin
                    o.mask_out = slot_mask[h];
                    o.references_out = slot_refs[h];
                end
            end
            default:
            begin
                o = '0;
            end
        endcase
        live_n = 0;
        for (int i = 0; i < ENTRIES; i++)
            live_n += int'(slot_live[i]);
        if (live_n > peak_live)
            peak_live = live_n;
        return o;
    endfunction

    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (calm_phase || roll < 55)
            return 0;
        else if (roll < 90)
            return $urandom_range(1, 3);
        else
            return $urandom_range(8, 30);
    endfunction

    function automatic rsp_t reply(input logic [STATUS_W-1:0] status,
                                   input logic [HANDLE_W-1:0] handle);
        rsp_t o;
        o = '0;
        o.status = status;
        o.allocated_handle = handle;
        return o;
    endfunction

    function automatic req_t random_req(input bit filling);
        req_t r;
        int   roll;
        int   live_idx[$];
        r.new_mask = {$urandom, $urandom};
        roll = $urandom_range(0, 9);
        if (roll == 0)
            r.new_mask = MASK_ONES;
        else if (roll == 1)
            r.new_mask = MASK_ZERO;
        roll = $urandom_range(0, 99);
        if (roll < 5)
            r.operation = OP_W'($urandom_range(OP_SPARE5, OP_SPARE7));
        else if (filling)
            r.operation = (roll < 45) ? OP_CREATE :
                          (roll < 60) ? OP_RETAIN :
                          (roll < 70) ? OP_UPDATE :
                          (roll < 85) ? OP_QUERY : OP_RELEASE;
        else
            r.operation = (roll < 12) ? OP_CREATE :
                          (roll < 55) ? OP_RELEASE :
                          (roll < 65) ? OP_RETAIN :
                          (roll < 75) ? OP_UPDATE : OP_QUERY;
        for (int i = 0; i < ENTRIES; i++)
            if (slot_live[i])
                live_idx.push_back(i);
        roll = $urandom_range(0, 99);
        if (roll < 80 && live_idx.size() > 0)
            r.handle = HANDLE_W'(live_idx[$urandom_range(0, live_idx.size() - 1)]);
        else if (roll < 92)
            r.handle = HANDLE_W'($urandom_range(0, ENTRIES - 1));
        else
            r.handle = HANDLE_W'($urandom_range(0, 255));
        return r;
    endfunction

    task automatic send_req(input req_t r, input bit typed, input rsp_t want);
        int   gap;
        rsp_t predicted;
        gap = pick_gap();
        if (gap > 0)
        begin
            req_if.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_if.valid <= 1'b1;
        req_if.data  <= r;
        @(posedge clk);
        while (!req_if.ready)
            @(posedge clk);
        predicted = apply_handle_op(r);
        pending_rsp.push_back(typed ? want : predicted);
    endtask

    task automatic add_step(input logic [OP_W-1:0] operation,
                            input logic [HANDLE_W-1:0] handle,
                            input logic [MASK_W-1:0] new_mask,
                            input int reps, input bit typed, input rsp_t want);
        step_t s;
        s.operation = operation;
        s.handle    = handle;
        s.new_mask  = new_mask;
        s.reps      = 8'(reps);
        s.typed     = typed;
        s.want      = want;
        directed_steps.push_back(s);
    endtask

    task automatic check_result(input rsp_t got);
        rsp_t want;
        if (pending_rsp.size() == 0)
        begin
            $display("%0t: unexpected transaction, actual %h", $time, got);
            error_count++;
        end
        else
        begin
            want = pending_rsp.pop_front();
            checked_count++;
            case (want.status)
                ST_OK:   ok_count++;
                ST_BAD:  bad_count++;
                ST_FULL: full_count++;
                default: ;
            endcase
            if (got.status !== want.status)
            begin
                $display("%0t: status expected %0d actual %0d",
                         $time, want.status, got.status);
                error_count++;
            end
            if (got.allocated_handle !== want.allocated_handle)
            begin
                $display("%0t: allocated_handle expected %0d actual %0d",
                         $time, want.allocated_handle, got.allocated_handle);
                error_count++;
            end
            if (got.mask_out !== want.mask_out)
            begin
                $display("%0t: mask_out expected %h actual %h",
                         $time, want.mask_out, got.mask_out);
                error_count++;
            end
            if (got.references_out !== want.references_out)
            begin
                $display("%0t: references_out expected %0d actual %0d",
                         $time, want.references_out, got.references_out);
                error_count++;
            end
        end
    endtask

    always @(posedge clk)
    begin
        if (rst_n && rsp_if.valid && rsp_if.ready)
            check_result(rsp_if.data);
        if (stall_left > 0)
        begin
            rsp_if.ready <= 1'b0;
            stall_left <= stall_left - 1;
        end
        else if (!calm_phase && $urandom_range(0, 99) < 25)
        begin
            rsp_if.ready <= 1'b0;
            stall_left <= ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40)
                                                      : $urandom_range(0, 2);
        end
        else
        begin
            rsp_if.ready <= 1'b1;
        end
    end

    initial
    begin
        #10_000_000;
        $display("*** FAILED ***");
        $finish;
    end

    initial
    begin
        step_t s;
        bit    filling;
        rst_n = 1'b0;
        req_if.valid = 1'b0;
        req_if.data = '0;
        rsp_if.ready = 1'b0;
        stall_left = 0;
        calm_phase = 1'b0;
        error_count = 0;
        checked_count = 0;
        ok_count = 0;
        bad_count = 0;
        full_count = 0;
        peak_live = 0;
        filling = 1'b1;
        for (int i = 0; i < ENTRIES; i++)
        begin
            slot_live[i] = 1'b0;
            slot_refs[i] = '0;
            slot_mask[i] = '0;
        end

        add_step(OP_QUERY,   0,   MASK_ZERO, 1,  1, reply(ST_BAD, 0));
        add_step(OP_RETAIN,  255, MASK_ZERO, 1,  1, reply(ST_BAD, 0));
        add_step(OP_UPDATE,  0,   MASK_ONES, 1,  1, reply(ST_BAD, 0));
        add_step(OP_RELEASE, 0,   MASK_ZERO, 1,  1, reply(ST_OK, 0));
        add_step(OP_CREATE,  0,   MASK_ONES, 1,  1, reply(ST_OK, 0));
        add_step(OP_QUERY,   0,   MASK_ZERO, 1,  0, '0);
        add_step(OP_CREATE,  255, MASK_ZERO, 15, 0, '0);
        add_step(OP_CREATE,  0,   MASK_ONES, 1,  1, reply(ST_FULL, 0));
        add_step(OP_RETAIN,  15,  MASK_ZERO, 3,  0, '0);
        add_step(OP_QUERY,   15,  MASK_ZERO, 1,  0, '0);
        add_step(OP_UPDATE,  7,   MASK_ALT,  1,  0, '0);
        add_step(OP_QUERY,   7,   MASK_ZERO, 1,  0, '0);
        add_step(OP_UPDATE,  16,  MASK_ONES, 1,  1, reply(ST_BAD, 0));
        add_step(OP_QUERY,   255, MASK_ZERO, 1,  1, reply(ST_BAD, 0));
        add_step(OP_RELEASE, 0,   MASK_ZERO, 1,  1, reply(ST_OK, 0));
        add_step(OP_QUERY,   0,   MASK_ZERO, 1,  1, reply(ST_BAD, 0));
        add_step(OP_CREATE,  9,   ~MASK_ALT, 1,  1, reply(ST_OK, 0));
        add_step(OP_QUERY,   0,   MASK_ZERO, 1,  0, '0);
        add_step(OP_SPARE5,  3,   MASK_ZERO, 1,  1, reply(ST_OK, 0));
        add_step(OP_SPARE6,  255, MASK_ONES, 1,  1, reply(ST_OK, 0));
        add_step(OP_SPARE7,  15,  MASK_ALT,  1,  1, reply(ST_OK, 0));
        add_step(OP_RELEASE, 200, MASK_ZERO, 1,  1, reply(ST_OK, 0));
        add_step(OP_RELEASE, 15,  MASK_ZERO, 4,  0, '0);
        add_step(OP_RETAIN,  15,  MASK_ZERO, 1,  1, reply(ST_BAD, 0));

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_steps[i])
        begin
            s = directed_steps[i];
            repeat (s.reps)
                send_req('{s.operation, s.handle, s.new_mask}, s.typed, s.want);
        end

        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            if (n % PHASE_LEN == 0)
            begin
                filling = ($urandom_range(0, 1) == 1);
                calm_phase <= ($urandom_range(0, 3) == 0);
            end
            send_req(random_req(filling), 1'b0, '0);
        end
        req_if.valid <= 1'b0;

        while (pending_rsp.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);

        $display("Checked %0d responses: %0d ok, %0d bad handle, %0d table full.",
                 checked_count, ok_count, bad_count, full_count);
        $display("Peak occupancy was %0d of %0d entries.", peak_live, ENTRIES);
        if (error_count == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end
endmodule
